// ----- sv/dds_pkg.sv -----
// Package for the task-graph scheduler: sizes, command and status codes.
// No dependencies.
`default_nettype none
package dds_pkg;
    localparam int NODES = 16;
    localparam int MAX_CHILDREN = 8;
    localparam int NW = $clog2(NODES);
    localparam int CW = $clog2(MAX_CHILDREN);
    localparam int CLW = NW + CW;
    localparam logic [2:0] CMD_INIT = 3'd0;
    localparam logic [2:0] CMD_WEIGHT = 3'd1;
    localparam logic [2:0] CMD_EDGE = 3'd2;
    localparam logic [2:0] CMD_SUBMIT = 3'd3;
    localparam logic [2:0] CMD_YIELD = 3'd4;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_BUSY = 2'd3;
endpackage
`default_nettype wire

// ----- sv/dag_dependency_scheduler_unit.sv -----
// Top level of the task-graph scheduler: node table, child memory, ready list. Uses dds_pkg.
// Each accepted command goes through S_OUT into the output register; a submit that queues
// first walks the ready list in S_INS, and a yield steps S_SHF, S_CRD and S_CHK for each child,
// with an S_INS walk for each child made ready. Throughput: one item at a time.
// A result waiting in the output register holds off the next item until it is taken.
// Reset (synchronous) clears all counts and flags; the child memory and ready list are not.
`default_nettype none
module dag_dependency_scheduler_unit import dds_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [3:0]  i_node,
    input  wire logic [3:0]  i_other_node,
    input  wire logic signed [15:0] i_weight,
    input  wire logic [31:0] i_context_tag,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [3:0]       o_run_node,
    output logic signed [15:0] o_run_weight,
    output logic [31:0]      o_run_context
);
    localparam logic [2:0] S_IDLE = 3'd0, S_CRD = 3'd1, S_CHK = 3'd2,
        S_INS = 3'd3, S_SHF = 3'd4, S_OUT = 3'd5;

    logic [2:0] r_st;
    logic [15:0] r_wt [NODES];
    logic [31:0] r_ctx [NODES];
    logic [7:0] r_pend [NODES];
    logic [NODES-1:0] r_done, r_q;
    logic [CW:0] r_cc [NODES];
    logic [NW-1:0] r_mem [NODES*MAX_CHILDREN];
    logic [NW-1:0] r_rdy [NODES];
    logic [NW:0] r_rc;
    logic [NW-1:0] r_md;
    logic [CW:0] r_ci;
    logic [NW-1:0] r_h, r_k;
    logic [NW:0] r_pos;
    logic r_fromy;
    logic [1:0] r_sta;
    logic [NW-1:0] r_rn;
    logic [15:0] r_rw;
    logic [31:0] r_rcx;
    logic r_ov;

    logic [NW-1:0] node_ix, child_ix;
    assign node_ix = i_node[NW-1:0];
    assign child_ix = i_other_node[NW-1:0];
    assign o_stall = (r_st != S_IDLE) || (r_ov && i_stall);
    assign o_valid = r_ov;
    assign o_status = r_sta;
    assign o_run_node = 4'(r_rn);
    assign o_run_weight = r_rw;
    assign o_run_context = r_rcx;

    logic acc;
    assign acc = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (r_st == S_CRD)
            r_md <= r_mem[{r_h, r_ci[CW-1:0] - CW'(1)}];
        if (acc && i_cmd == CMD_EDGE && r_cc[node_ix] < (CW+1)'(MAX_CHILDREN))
            r_mem[{node_ix, r_cc[node_ix][CW-1:0]}] <= child_ix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0; r_rc <= '0;
            r_done <= '0; r_q <= '0; r_fromy <= 1'b0;
            for (int i = 0; i < NODES; i++) begin
                r_wt[i] <= '0; r_ctx[i] <= '0; r_pend[i] <= '0; r_cc[i] <= '0;
            end
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (acc) begin
                    r_sta <= ST_OK; r_rn <= '0; r_rw <= '0; r_rcx <= '0;
                    r_st <= S_OUT; r_fromy <= 1'b0;
                    unique case (i_cmd)
                        CMD_INIT: if (r_q[node_ix]) r_sta <= ST_BUSY;
                            else begin
                                r_ctx[node_ix] <= i_context_tag; r_wt[node_ix] <= '0;
                                r_pend[node_ix] <= '0; r_done[node_ix] <= 1'b0;
                                r_cc[node_ix] <= '0;
                            end
                        CMD_WEIGHT: r_wt[node_ix] <= i_weight;
                        CMD_EDGE: if (r_cc[node_ix] >= (CW+1)'(MAX_CHILDREN)) r_sta <= ST_FULL;
                            else begin
                                r_cc[node_ix] <= r_cc[node_ix] + 1'b1;
                                if (r_pend[child_ix] != 8'hFF)
                                    r_pend[child_ix] <= r_pend[child_ix] + 1'b1;
                            end
                        CMD_SUBMIT: if (r_pend[node_ix] == 0 && !r_done[node_ix]
                                        && !r_q[node_ix] && r_rc < (NW+1)'(NODES)) begin
                                r_k <= node_ix; r_pos <= '0; r_st <= S_INS;
                            end
                        CMD_YIELD: if (r_rc == 0) r_sta <= ST_EMPTY;
                            else begin
                                r_h <= r_rdy[0]; r_rn <= r_rdy[0];
                                r_rw <= r_wt[r_rdy[0]]; r_rcx <= r_ctx[r_rdy[0]];
                                r_q[r_rdy[0]] <= 1'b0; r_done[r_rdy[0]] <= 1'b1;
                                for (int i = 0; i < NODES - 1; i++) r_rdy[i] <= r_rdy[i+1];
                                r_rc <= r_rc - 1'b1; r_ci <= r_cc[r_rdy[0]];
                                r_fromy <= 1'b1; r_st <= S_SHF;
                            end
                        default: ;
                    endcase
                end
                S_SHF: r_st <= (r_ci == 0) ? S_OUT : S_CRD;
                S_CRD: begin r_ci <= r_ci - 1'b1; r_st <= S_CHK; end
                S_CHK: begin
                    r_st <= S_SHF;
                    if (r_pend[r_md] != 0) begin
                        r_pend[r_md] <= r_pend[r_md] - 1'b1;
                        if (r_pend[r_md] == 8'd1 && !r_done[r_md] && !r_q[r_md]
                            && r_rc < (NW+1)'(NODES)) begin
                            r_k <= r_md; r_pos <= '0; r_st <= S_INS;
                        end
                    end
                end
                S_INS: begin
                    if (r_pos < r_rc && $signed(r_wt[r_rdy[r_pos[NW-1:0]]])
                            >= $signed(r_wt[r_k])) r_pos <= r_pos + 1'b1;
                    else begin
                        for (int i = 1; i < NODES; i++)
                            if ((NW+1)'(i) > r_pos && (NW+1)'(i) <= r_rc)
                                r_rdy[i] <= r_rdy[i-1];
                        r_rdy[r_pos[NW-1:0]] <= r_k;
                        r_rc <= r_rc + 1'b1; r_q[r_k] <= 1'b1;
                        r_st <= r_fromy ? S_SHF : S_OUT;
                    end
                end
                S_OUT: if (!r_ov || !i_stall) begin r_ov <= 1'b1; r_st <= S_IDLE; end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
